// ----- rtl/bhpq_pkg.sv -----
// Package for the binary heap priority queue: sizes, entry and result types,
// operation and error codes, and the sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bhpq_pkg;

   // Storage and field sizes.
   localparam int CAPACITY = 64;
   localparam int KEY_W    = 16;
   localparam int PAY_W    = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Operation codes carried in the kind field of a request.
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_TOGGLE = 2'd2,
      OP_PEEK   = 2'd3
   } kind_type;

   // Error codes reported with every response.
   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_EMPTY = 2'd2
   } error_type;

   // One heap entry as stored in the memory.
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } entry_type;

   // Request handed from the top level to the engine.
   typedef struct packed {
      kind_type         kind;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } cmd_type;

   // Finished response handed from the engine to the output register.
   typedef struct packed {
      logic             done;
      logic [KEY_W-1:0] top_key;
      logic [PAY_W-1:0] top_payload;
      logic [CNT_W-1:0] entry_total;
      logic             is_empty;
      error_type        error_code;
   } result_type;

   // Sequencer states of the heap engine.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DEL_LD,
      ST_TG_RD,
      ST_TG_LD,
      ST_DN_RDL,
      ST_DN_RDR,
      ST_DN_CMP,
      ST_FIN_RD,
      ST_FIN_OUT
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/bhpq_req_if.sv -----
// Request channel of the heap priority queue: valid, ready and the request fields.
// Depends on bhpq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bhpq_req_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               kind;
   logic [bhpq_pkg::KEY_W-1:0] key;
   logic [bhpq_pkg::PAY_W-1:0] payload;

   modport source (output valid, output kind, output key, output payload, input ready);
   modport sink   (input valid, input kind, input key, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/bhpq_rsp_if.sv -----
// Response channel of the heap priority queue: valid, ready and the result fields.
// Depends on bhpq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bhpq_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bhpq_pkg::KEY_W-1:0] top_key;
   logic [bhpq_pkg::PAY_W-1:0] top_payload;
   logic [bhpq_pkg::CNT_W-1:0] entry_total;
   logic                       is_empty;
   logic [1:0]                 error_code;

   modport source (output valid, output top_key, output top_payload, output entry_total,
                   output is_empty, output error_code, input ready);
   modport sink   (input valid, input top_key, input top_payload, input entry_total,
                   input is_empty, input error_code, output ready);
endinterface

`default_nettype wire

// ----- rtl/bhpq_engine.sv -----
// Heap engine: entry memory, one shared key comparator and the sequencer that
// runs insert, delete, toggle and peek. Depends on bhpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bhpq_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start_order,
   input  wire logic                 cmd_valid,
   input  wire bhpq_pkg::cmd_type    cmd,
   output logic                      cmd_ready,
   input  wire logic                 out_free,
   output bhpq_pkg::result_type      result
);
   import bhpq_pkg::*;

   // Entry memory: one write and one registered read per cycle.
   entry_type mem [CAPACITY];
   entry_type rdata_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   entry_type          mem_wdata;
   logic               mem_re;
   logic [IDX_W-1:0]   mem_raddr;

   // Sequencer registers.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               flip_ff, flip_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   tog_ff, tog_in;
   entry_type          cur_ff, cur_in;
   entry_type          best_ff, best_in;
   logic               best_left_ff, best_left_in;
   kind_type           op_ff, op_in;
   error_type          err_ff, err_in;

   // Shared comparator: true when key a must sit strictly above key b.
   logic [KEY_W-1:0]   cmp_a, cmp_b;
   logic               above;
   logic               order_is_max;

   // Child and parent positions of the current hole.
   logic [IDX_W:0]     left_idx;
   logic [IDX_W+1:0]   right_idx;
   logic               left_ok, right_ok;
   logic [IDX_W-1:0]   parent_idx;

   assign order_is_max = start_order ^ flip_ff;
   assign above      = order_is_max ? (cmp_a > cmp_b) : (cmp_a < cmp_b);
   assign left_idx   = {pos_ff, 1'b1};
   assign right_idx  = {1'b0, left_idx} + (IDX_W+2)'(1);
   assign left_ok    = {1'b0, left_idx} < (IDX_W+2)'(count_ff);
   assign right_ok   = right_idx < (IDX_W+2)'(count_ff);
   assign parent_idx = (pos_ff - IDX_W'(1)) >> 1;

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         flip_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         flip_ff  <= flip_in;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      tog_ff       <= tog_in;
      cur_ff       <= cur_in;
      best_ff      <= best_in;
      best_left_ff <= best_left_in;
      op_ff        <= op_in;
      err_ff       <= err_in;
   end

   // Next state, memory control and comparator operands.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      flip_in      = flip_ff;
      pos_in       = pos_ff;
      tog_in       = tog_ff;
      cur_in       = cur_ff;
      best_in      = best_ff;
      best_left_in = best_left_ff;
      op_in        = op_ff;
      err_in       = err_ff;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff;
      mem_wdata    = cur_ff;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      cmp_a        = cur_ff.key;
      cmp_b        = rdata_ff.key;
      cmd_ready    = 1'b0;
      result       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               op_in  = cmd.kind;
               err_in = ERR_NONE;
               state_in = ST_FIN_RD;
               unique case (cmd.kind)
                  OP_INSERT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        err_in = ERR_FULL;
                     end else begin
                        count_in      = count_ff + CNT_W'(1);
                        pos_in        = IDX_W'(count_ff);
                        cur_in.key    = cmd.key;
                        cur_in.payload = cmd.payload;
                        state_in      = ST_UP_RD;
                     end
                  end
                  OP_DELETE: begin
                     if (count_ff == '0) begin
                        err_in = ERR_EMPTY;
                     end else begin
                        count_in  = count_ff - CNT_W'(1);
                        mem_re    = 1'b1;
                        mem_raddr = IDX_W'(count_ff - CNT_W'(1));
                        pos_in    = '0;
                        state_in  = ST_DEL_LD;
                     end
                  end
                  OP_TOGGLE: begin
                     flip_in  = ~flip_ff;
                     tog_in   = IDX_W'(count_ff >> 1);
                     state_in = ST_TG_RD;
                  end
                  default: begin
                     state_in = ST_FIN_RD;
                  end
               endcase
            end
         end

         // Sift up: fetch the parent of the hole, or settle at the root.
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               state_in = ST_FIN_RD;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = parent_idx;
               state_in  = ST_UP_CMP;
            end
         end

         // Move the parent down into the hole, or drop the new entry here.
         ST_UP_CMP: begin
            cmp_a  = cur_ff.key;
            cmp_b  = rdata_ff.key;
            mem_we = 1'b1;
            if (above) begin
               mem_wdata = rdata_ff;
               pos_in    = parent_idx;
               state_in  = ST_UP_RD;
            end else begin
               state_in  = ST_FIN_RD;
            end
         end

         // The last entry becomes the one to sift down from the root.
         ST_DEL_LD: begin
            cur_in = rdata_ff;
            if (count_ff == '0) begin
               state_in = ST_FIN_RD;
            end else begin
               state_in = ST_DN_RDL;
            end
         end

         // Rebuild loop: next internal node, from the last one back to the root.
         ST_TG_RD: begin
            if (tog_ff == '0) begin
               state_in = ST_FIN_RD;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = tog_ff - IDX_W'(1);
               pos_in    = tog_ff - IDX_W'(1);
               tog_in    = tog_ff - IDX_W'(1);
               state_in  = ST_TG_LD;
            end
         end

         ST_TG_LD: begin
            cur_in   = rdata_ff;
            state_in = ST_DN_RDL;
         end

         // Sift down: fetch the left child, or settle when there is none.
         ST_DN_RDL: begin
            if (left_ok) begin
               mem_re    = 1'b1;
               mem_raddr = IDX_W'(left_idx);
               state_in  = ST_DN_RDR;
            end else begin
               mem_we   = 1'b1;
               state_in = (op_ff == OP_TOGGLE) ? ST_TG_RD : ST_FIN_RD;
            end
         end

         // Left child against the sifted entry; fetch the right child if present.
         ST_DN_RDR: begin
            cmp_a = rdata_ff.key;
            cmp_b = cur_ff.key;
            if (right_ok) begin
               best_in      = above ? rdata_ff : cur_ff;
               best_left_in = above;
               mem_re       = 1'b1;
               mem_raddr    = IDX_W'(right_idx);
               state_in     = ST_DN_CMP;
            end else if (above) begin
               mem_we    = 1'b1;
               mem_wdata = rdata_ff;
               pos_in    = IDX_W'(left_idx);
               state_in  = ST_DN_RDL;
            end else begin
               mem_we   = 1'b1;
               state_in = (op_ff == OP_TOGGLE) ? ST_TG_RD : ST_FIN_RD;
            end
         end

         // Right child against the better of the two so far, then move.
         ST_DN_CMP: begin
            cmp_a  = rdata_ff.key;
            cmp_b  = best_ff.key;
            mem_we = 1'b1;
            if (above) begin
               mem_wdata = rdata_ff;
               pos_in    = IDX_W'(right_idx);
               state_in  = ST_DN_RDL;
            end else if (best_left_ff) begin
               mem_wdata = best_ff;
               pos_in    = IDX_W'(left_idx);
               state_in  = ST_DN_RDL;
            end else begin
               state_in = (op_ff == OP_TOGGLE) ? ST_TG_RD : ST_FIN_RD;
            end
         end

         // Read the root for the response.
         ST_FIN_RD: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_in  = ST_FIN_OUT;
         end

         // Hand the response over once the output register can take it.
         ST_FIN_OUT: begin
            if (out_free) begin
               result.done        = 1'b1;
               result.entry_total = count_ff;
               result.is_empty    = (count_ff == '0);
               result.error_code  = err_ff;
               if (count_ff != '0) begin
                  result.top_key     = rdata_ff.key;
                  result.top_payload = rdata_ff.payload;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/binary_heap_priority_queue.sv -----
// Top level of the binary heap priority queue: order register, request and
// response channels, output register. Depends on bhpq_pkg, bhpq_req_if,
// bhpq_rsp_if and bhpq_engine.
//
// A min-heap or max-heap of up to 64 key and payload entries. Each request
// inserts, deletes the top, toggles the order with a bottom-up rebuild, or
// peeks, and returns one response with the top entry, the count and an error
// code. Requests are taken one at a time; ready is high only while the engine
// is idle and reset is low. The engine runs an entry memory with one write and
// one read port and one key comparator under a sequencer, so the time per
// request is set by memory reads per heap level: a peek or a rejected request
// only reads the root, an insert climbs level by level towards the root, a
// delete descends level by level from it, and a toggle runs one sift-down per
// internal node. The response waits in an output register, and the next
// request is taken while it is still there.
`timescale 1ns / 1ps
`default_nettype none

module binary_heap_priority_queue (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  csr_write_enable,
   input  wire logic  csr_write_data,
   bhpq_req_if.sink   req_chan,
   bhpq_rsp_if.source rsp_chan
);
   import bhpq_pkg::*;

   logic       start_order_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type result;
   cmd_type    cmd;
   logic       cmd_ready;
   logic       out_free;

   // Order register.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_order_ff <= 1'b0;
      end else if (csr_write_enable) begin
         start_order_ff <= csr_write_data;
      end
   end

   // Request fields into the engine; nothing is taken while reset is high.
   assign cmd.kind     = kind_type'(req_chan.kind);
   assign cmd.key      = req_chan.key;
   assign cmd.payload  = req_chan.payload;
   assign req_chan.ready = cmd_ready && !reset;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   bhpq_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .start_order (start_order_ff),
      .cmd_valid   (req_chan.valid),
      .cmd         (cmd),
      .cmd_ready   (cmd_ready),
      .out_free    (out_free),
      .result      (result)
   );

   // Output register: loaded when the engine finishes, cleared when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.top_key     = rsp_ff.top_key;
   assign rsp_chan.top_payload = rsp_ff.top_payload;
   assign rsp_chan.entry_total = rsp_ff.entry_total;
   assign rsp_chan.is_empty    = rsp_ff.is_empty;
   assign rsp_chan.error_code  = rsp_ff.error_code;

endmodule

`default_nettype wire
